@@ hw/rtl/urx_pkg.sv @@
// urx_pkg: shared constants, codes and types of the receive ring framer
// no dependencies; compiled first
package urx_pkg;

    // buffer geometry
    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;
    localparam int PTR_W    = $clog2(DEPTH);

    // field widths
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 2;
    localparam int LEN_W      = 7;
    localparam int TMO_W      = 16;
    localparam int MARGIN_W   = 10;
    localparam int IDLE_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int AVAIL_W = PTR_W + 1;
    localparam int CMP_W   = (AVAIL_W > LEN_W) ? AVAIL_W : LEN_W;
    localparam int SUM_W   = ((PTR_W > MARGIN_W) ? PTR_W : MARGIN_W) + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MARGIN  = 2'd1;

    // register reset values
    localparam logic [TMO_W-1:0]    TMO_RESET    = 16'd10;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd10;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [TMO_W-1:0]    idle_timeout;
        logic [MARGIN_W-1:0] full_margin;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } t_mem_req;

endpackage

@@ hw/rtl/urx_intf.sv @@
// urx interfaces: input item, result item and register write channels
// depends on urx_pkg
interface urx_in_if;
    logic                         valid;
    logic                         ready;
    logic [urx_pkg::OP_W-1:0]     op;
    logic [urx_pkg::BYTE_W-1:0]   rx_byte;
    logic [urx_pkg::LEN_W-1:0]    max_len;

    modport source(output valid, op, rx_byte, max_len, input ready);
    modport sink(input valid, op, rx_byte, max_len, output ready);
endinterface

interface urx_out_if;
    logic                         valid;
    logic                         ready;
    logic [urx_pkg::BYTE_W-1:0]   data;
    logic                         has_data;
    logic                         last;

    modport source(output valid, data, has_data, last, input ready);
    modport sink(input valid, data, has_data, last, output ready);
endinterface

interface urx_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [urx_pkg::CFG_IDX_W-1:0]    index;
    logic [urx_pkg::CFG_DATA_W-1:0]   data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/uart_rx_ring_idle_framer_core.sv @@
// channel   dir   payload                    transaction
// i_in      in    op, rx_byte, max_len       one received byte, tick or read request
// o_out     out   data, has_data, last       one frame byte or empty marker
// i_cfg     in    index, data                one register write
//
// byte and tick items leave the controller idle, ready to take the next item.
// a read fetches one byte per cycle from the single read port of the byte store
// while the result register is not stalled; an empty read gives one empty marker.
// reset is synchronous, active low; the byte store is not cleared.
// a stalled result register holds the read walk and the input with it; once the
// final result of a read is loaded, byte and tick items pass while it waits.
//
// top level: register file, byte store and controller
// depends on urx_pkg, urx_intf, urx_store, urx_ctrl
module uart_rx_ring_idle_framer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    urx_in_if.sink     i_in,
    urx_out_if.source  o_out,
    urx_cfg_if.sink    i_cfg
);
    import urx_pkg::*;

    t_cfg              r_cfg;
    t_mem_req          mem_req;
    logic [BYTE_W-1:0] rd_data;

    // register writes, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout <= TMO_RESET;
            r_cfg.full_margin  <= MARGIN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IDLE_TIMEOUT: r_cfg.idle_timeout <= i_cfg.data[TMO_W-1:0];
                CFG_FULL_MARGIN:  r_cfg.full_margin  <= i_cfg.data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    urx_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    urx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cfg     (r_cfg),
        .o_mem     (mem_req),
        .i_rd_data (rd_data)
    );

    // an empty marker always closes its read request
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_data) |-> o_out.last)
        else $error("empty result without last");

    // the store is never written while a read walk fetches from it
    a_no_wr_during_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> !mem_req.rd_en)
        else $error("store write overlaps read");

    // a read request blocks new items in the following cycle
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.op == OP_READ)) |=> !i_in.ready)
        else $error("item taken right after read request");

endmodule

@@ hw/rtl/urx_store.sv @@
// urx_store: byte ring storage, one write port and one registered read port
// depends on urx_pkg
module urx_store (
    input  logic                       i_clk,
    input  urx_pkg::t_mem_req          i_req,
    output logic [urx_pkg::BYTE_W-1:0] o_rd_data
);
    import urx_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/urx_ctrl.sv @@
// urx_ctrl: pointers, idle framing, read sequencer and output register
// depends on urx_pkg, urx_intf; drives urx_store through a request struct
module urx_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    urx_in_if.sink                     i_in,
    urx_out_if.source                  o_out,
    input  urx_pkg::t_cfg              i_cfg,
    output urx_pkg::t_mem_req          o_mem,
    input  logic [urx_pkg::BYTE_W-1:0] i_rd_data
);
    import urx_pkg::*;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wr_pos, n_wr_pos;
    logic [PTR_W-1:0]  r_rd_pos, n_rd_pos;
    logic [PTR_W-1:0]  r_end_pos, n_end_pos;
    logic              r_receiving, n_receiving;
    logic              r_frame_ready, n_frame_ready;
    logic [IDLE_W-1:0] r_idle, n_idle;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_fetch_vld, n_fetch_vld;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic              r_out_has, n_out_has;
    logic              r_out_last, n_out_last;

    logic              in_ready;
    logic              in_acc;
    logic              out_free;
    logic              load;
    logic              issue;
    logic              emit_empty;
    logic [IDLE_W-1:0] idle_inc;
    logic              timed_out;
    logic              near_full;
    logic [AVAIL_W-1:0] avail;
    logic [LEN_W-1:0]  mlen_sat;
    logic [LEN_W-1:0]  read_len;
    logic [PTR_W-1:0]  wr_pos_inc;
    logic [PTR_W-1:0]  rd_pos_inc;

    // handshake and sequencer strobes
    always_comb begin
        in_ready   = (r_state == ST_IDLE);
        out_free   = !r_out_valid || o_out.ready;
        load       = (r_state == ST_READ) && r_fetch_vld && out_free;
        issue      = (r_state == ST_READ) && (r_left != '0) && (!r_fetch_vld || load);
        emit_empty = (r_state == ST_EMPTY) && out_free;
    end

    assign in_acc = i_in.valid && in_ready;

    // pointer wrap and frame length
    always_comb begin
        wr_pos_inc = (r_wr_pos == PTR_LAST) ? '0 : r_wr_pos + 1'b1;
        rd_pos_inc = (r_rd_pos == PTR_LAST) ? '0 : r_rd_pos + 1'b1;
        if (r_end_pos >= r_rd_pos) begin
            avail = AVAIL_W'(r_end_pos) - AVAIL_W'(r_rd_pos);
        end else begin
            avail = AVAIL_W'(r_end_pos) + AVAIL_W'(DEPTH) - AVAIL_W'(r_rd_pos);
        end
        mlen_sat = (i_in.max_len > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : i_in.max_len;
        read_len = (CMP_W'(avail) > CMP_W'(mlen_sat)) ? mlen_sat : LEN_W'(avail);
    end

    // idle tick and frame close conditions
    always_comb begin
        idle_inc  = (r_idle != IDLE_MAX) ? r_idle + 1'b1 : r_idle;
        timed_out = r_receiving && !r_frame_ready;
        near_full = (r_wr_pos < r_rd_pos)
                 && (SUM_W'(r_wr_pos) + SUM_W'(i_cfg.full_margin) == SUM_W'(r_rd_pos));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in.op == OP_READ)) begin
                    n_state = (r_frame_ready && (read_len != '0)) ? ST_READ : ST_EMPTY;
                end
            end
            ST_EMPTY: begin
                if (emit_empty) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (load && (r_left == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_wr_pos      = r_wr_pos;
        n_rd_pos      = r_rd_pos;
        n_end_pos     = r_end_pos;
        n_receiving   = r_receiving;
        n_frame_ready = r_frame_ready;
        n_idle        = r_idle;
        n_left        = r_left;
        n_fetch_vld   = issue || (r_fetch_vld && !load);
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_data    = r_out_data;
        n_out_has     = r_out_has;
        n_out_last    = r_out_last;

        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_wr_pos;
        o_mem.wr_data = i_in.rx_byte;
        o_mem.rd_en   = issue;
        o_mem.rd_addr = r_rd_pos;

        if (in_acc) begin
            case (i_in.op)
                OP_BYTE: begin
                    o_mem.wr_en = 1'b1;
                    n_wr_pos    = wr_pos_inc;
                    n_receiving = 1'b1;
                    n_idle      = '0;
                end
                OP_TICK: begin
                    n_idle = idle_inc;
                    if ((idle_inc > IDLE_W'(i_cfg.idle_timeout)) && (timed_out || near_full))
                    begin
                        n_frame_ready = 1'b1;
                        n_receiving   = 1'b0;
                        n_end_pos     = r_wr_pos;
                    end
                end
                OP_READ: begin
                    n_frame_ready = 1'b0;
                    n_left        = read_len;
                end
                default: ;
            endcase
        end

        // read sequencer: address walk and byte hand-off
        if (issue) begin
            n_rd_pos = rd_pos_inc;
            n_left   = r_left - 1'b1;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_out_data  = i_rd_data;
            n_out_has   = 1'b1;
            n_out_last  = (r_left == '0);
        end
        if (emit_empty) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_has   = 1'b0;
            n_out_last  = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wr_pos      <= '0;
            r_rd_pos      <= '0;
            r_end_pos     <= '0;
            r_receiving   <= 1'b0;
            r_frame_ready <= 1'b0;
            r_idle        <= '0;
            r_left        <= '0;
            r_fetch_vld   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_wr_pos      <= n_wr_pos;
            r_rd_pos      <= n_rd_pos;
            r_end_pos     <= n_end_pos;
            r_receiving   <= n_receiving;
            r_frame_ready <= n_frame_ready;
            r_idle        <= n_idle;
            r_left        <= n_left;
            r_fetch_vld   <= n_fetch_vld;
            r_out_valid   <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.data     = r_out_data;
    assign o_out.has_data = r_out_has;
    assign o_out.last     = r_out_last;

endmodule
